[sv/i2cs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the I2C slave byte sequencer.
// No dependencies; imported by every module of the block.
package i2cs_pkg;

	// Both byte queues share one depth
	localparam int Q_DEPTH = 16;
	localparam int PTR_W   = $clog2(Q_DEPTH);
	localparam int CNT_W   = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_OVF   = 2'd1,
		ACT_PUSH  = 2'd2,
		ACT_POP   = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		PH_ADDR      = 3'd0,
		PH_SEND      = 3'd1,
		PH_REQ_REPLY = 3'd2,
		PH_CHK_REPLY = 3'd3,
		PH_RECV      = 3'd4,
		PH_GET_ACK   = 3'd5
	} phase_t;

	// Queue strobes from the sequencer
	typedef struct packed {
		logic tx_push;
		logic tx_pop;
		logic rx_push;
		logic rx_pop;
	} q_ctl_t;

	// Queue status back to the sequencer
	typedef struct packed {
		logic tx_empty;
		logic tx_full;
		logic rx_empty;
		logic rx_full;
	} q_stat_t;

	// One result word
	typedef struct packed {
		phase_t     phase;
		logic       waiting_for_start;
		logic       sda_drive;
		logic       load_enable;
		logic [7:0] load_byte;
		logic       one_bit_shift;
		logic [7:0] host_data;
		logic       host_ok;
		logic       rx_dropped;
	} res_t;

endpackage

[sv/i2cs_fifo.sv]
`timescale 1ns / 1ps
// Byte queue of Q_DEPTH entries with head/tail pointers and a fill count.
// Depends on i2cs_pkg.
module i2cs_fifo (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       pop,
	input  logic [7:0] wdata,
	output logic [7:0] rdata,
	output logic       empty,
	output logic       full
);
	import i2cs_pkg::*;

	logic [7:0]       mem_q [Q_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(Q_DEPTH));
	assign rdata = mem_q[head_q];

	// Storage, no reset
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[tail_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				tail_q <= (tail_q == PTR_W'(Q_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (pop && !empty) begin
				head_q <= (head_q == PTR_W'(Q_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(Q_DEPTH))
		else $error("fifo count above depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && full && !pop) |=> $stable(count_q))
		else $error("push into full fifo changed count");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("empty fifo with unequal pointers");

endmodule

[sv/i2cs_seq.sv]
`timescale 1ns / 1ps
// Protocol sequencer: phase and armed registers plus next-state/result decode.
// Depends on i2cs_pkg.
module i2cs_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  i2cs_pkg::act_t      action,
	input  logic [7:0]          shift_byte,
	input  logic [6:0]          own_address,
	input  i2cs_pkg::q_stat_t   qstat,
	input  logic [7:0]          tx_rdata,
	input  logic [7:0]          rx_rdata,
	output i2cs_pkg::q_ctl_t    qctl,
	output i2cs_pkg::res_t      res
);
	import i2cs_pkg::*;

	phase_t phase_q, phase_n;
	logic   armed_q, armed_n;
	logic   addr_hit;
	q_ctl_t ctl_raw;

	assign addr_hit = (shift_byte == 8'h00) || (shift_byte[7:1] == own_address);

	// Next state and per-event result
	always_comb begin
		phase_n = phase_q;
		armed_n = armed_q;
		ctl_raw = '0;
		res     = '0;
		unique case (action)
			ACT_START: begin
				phase_n = PH_ADDR;
				armed_n = 1'b1;
			end
			ACT_OVF: begin
				if (armed_q) begin
					unique case (phase_q)
						PH_ADDR: begin
							if (addr_hit) begin
								phase_n         = shift_byte[0] ? PH_SEND : PH_RECV;
								res.load_enable = 1'b1;
							end else begin
								armed_n = 1'b0;
							end
						end
						PH_SEND, PH_CHK_REPLY: begin
							if (phase_q == PH_CHK_REPLY && shift_byte != 8'h00) begin
								armed_n = 1'b0;  // master NACK
							end else if (!qstat.tx_empty) begin
								ctl_raw.tx_pop  = 1'b1;
								phase_n         = PH_REQ_REPLY;
								res.load_enable = 1'b1;
								res.load_byte   = tx_rdata;
							end else begin
								armed_n = 1'b0;
							end
						end
						PH_REQ_REPLY: begin
							phase_n         = PH_CHK_REPLY;
							res.load_enable = 1'b1;
						end
						PH_RECV: begin
							phase_n = PH_GET_ACK;
						end
						PH_GET_ACK: begin
							ctl_raw.rx_push = !qstat.rx_full;
							res.rx_dropped  = qstat.rx_full;
							phase_n         = PH_RECV;
							res.load_enable = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ACT_PUSH: begin
				ctl_raw.tx_push = !qstat.tx_full;
				res.host_ok     = !qstat.tx_full;
			end
			ACT_POP: begin
				ctl_raw.rx_pop = !qstat.rx_empty;
				res.host_ok    = !qstat.rx_empty;
				res.host_data  = qstat.rx_empty ? 8'h00 : rx_rdata;
			end
			default: begin
			end
		endcase
		res.phase             = phase_n;
		res.waiting_for_start = !armed_n;
		res.sda_drive         = armed_n &&
			(phase_n == PH_SEND || phase_n == PH_REQ_REPLY || phase_n == PH_RECV);
		res.one_bit_shift     = armed_n &&
			(phase_n == PH_SEND || phase_n == PH_CHK_REPLY || phase_n == PH_RECV);
	end

	assign qctl = adv ? ctl_raw : '0;

	// Protocol state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ADDR;
			armed_q <= 1'b0;
		end else if (adv) begin
			phase_q <= phase_n;
			armed_q <= armed_n;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && action == ACT_OVF && !armed_q) |=> (!armed_q && $stable(phase_q)))
		else $error("overflow while waiting changed state");
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones({qctl.tx_push, qctl.tx_pop, qctl.rx_push, qctl.rx_pop}) <= 1)
		else $error("more than one queue strobe per word");
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && action == ACT_START) |=> (armed_q && phase_q == PH_ADDR))
		else $error("start did not arm address check");

endmodule

[sv/i2c_slave_byte_sequencer_top.sv]
`timescale 1ns / 1ps
// Top level of the I2C slave byte sequencer: input register, sequencer,
// transmit and receive queues, result register. Depends on i2cs_pkg,
// i2cs_fifo and i2cs_seq.
//
// Usage:
//  - Input channel (in_valid/in_ready) takes one event word: action,
//    shift_byte, host_byte. Output channel (out_valid/out_ready) gives one
//    result word per event, in order.
//  - cfg_we/cfg_wdata write own_address; write only while idle.
//  - An accepted word is held in the input register and is decoded into the
//    result register once that register is free or being drained; its result
//    is then on the outputs until out_ready takes it.
//  - Throughput: one word per cycle while out_ready stays high. Input and
//    result registers decouple the sides; protocol state and queue pointers
//    are updated in the single cycle the word moves from one to the other.
//  - When out_ready is low the result register holds, the input register
//    fills, and in_ready drops only once both are occupied.
//  - Reset (arst_n low): waiting for start, phase address check, both queues
//    empty, own_address zero, no word in flight. No clearing pass.
module i2c_slave_byte_sequencer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [7:0] shift_byte,
	input  logic [7:0] host_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] phase,
	output logic       waiting_for_start,
	output logic       sda_drive,
	output logic       load_enable,
	output logic [7:0] load_byte,
	output logic       one_bit_shift,
	output logic [7:0] host_data,
	output logic       host_ok,
	output logic       rx_dropped
);
	import i2cs_pkg::*;

	logic [6:0] own_address_q;
	logic       valid_s1;
	act_t       action_s1;
	logic [7:0] shift_s1;
	logic [7:0] host_s1;
	logic       out_valid_q;
	res_t       res_q;
	res_t       res_n;
	logic       adv;
	q_ctl_t     qctl;
	q_stat_t    qstat;
	logic [7:0] tx_rdata;
	logic [7:0] rx_rdata;

	// Handshake: move a word when the result register is free or draining
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= '0;
		end else if (cfg_we) begin
			own_address_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= act_t'(action);
			shift_s1  <= shift_byte;
			host_s1   <= host_byte;
		end
	end

	i2cs_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.action      (action_s1),
		.shift_byte  (shift_s1),
		.own_address (own_address_q),
		.qstat       (qstat),
		.tx_rdata    (tx_rdata),
		.rx_rdata    (rx_rdata),
		.qctl        (qctl),
		.res         (res_n)
	);

	i2cs_fifo u_tx_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (qctl.tx_push),
		.pop    (qctl.tx_pop),
		.wdata  (host_s1),
		.rdata  (tx_rdata),
		.empty  (qstat.tx_empty),
		.full   (qstat.tx_full)
	);

	i2cs_fifo u_rx_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (qctl.rx_push),
		.pop    (qctl.rx_pop),
		.wdata  (shift_s1),
		.rdata  (rx_rdata),
		.empty  (qstat.rx_empty),
		.full   (qstat.rx_full)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_n;
		end
	end

	assign out_valid         = out_valid_q;
	assign phase             = res_q.phase;
	assign waiting_for_start = res_q.waiting_for_start;
	assign sda_drive         = res_q.sda_drive;
	assign load_enable       = res_q.load_enable;
	assign load_byte         = res_q.load_byte;
	assign one_bit_shift     = res_q.one_bit_shift;
	assign host_data         = res_q.host_data;
	assign host_ok           = res_q.host_ok;
	assign rx_dropped        = res_q.rx_dropped;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.load_enable || res_q.load_byte == 8'h00))
		else $error("load byte set without load enable");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.waiting_for_start) |-> (!res_q.sda_drive && !res_q.one_bit_shift))
		else $error("SDA driven while waiting for start");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.rx_dropped && res_q.host_ok))
		else $error("dropped byte and host access in one word");
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !in_ready) |=> valid_s1)
		else $error("stalled input word lost");

endmodule

[sim/tb_i2c_slave_byte_sequencer_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for i2c_slave_byte_sequencer_top: directed protocol walks,
// queue limits and random bus transactions, checked word by word against an in-bench
// predictor. Depends on i2cs_pkg and the RTL of the block.
module tb_i2c_slave_byte_sequencer_top;
	import i2cs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       cfg_we     = 1'b0;
	logic [6:0] cfg_wdata  = '0;
	logic       in_valid   = 1'b0;
	logic       in_ready;
	logic [1:0] action     = '0;
	logic [7:0] shift_byte = '0;
	logic [7:0] host_byte  = '0;
	logic       out_valid;
	logic       out_ready  = 1'b0;
	logic [2:0] phase;
	logic       waiting_for_start;
	logic       sda_drive;
	logic       load_enable;
	logic [7:0] load_byte;
	logic       one_bit_shift;
	logic [7:0] host_data;
	logic       host_ok;
	logic       rx_dropped;

	i2c_slave_byte_sequencer_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.action            (action),
		.shift_byte        (shift_byte),
		.host_byte         (host_byte),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.phase             (phase),
		.waiting_for_start (waiting_for_start),
		.sda_drive         (sda_drive),
		.load_enable       (load_enable),
		.load_byte         (load_byte),
		.one_bit_shift     (one_bit_shift),
		.host_data         (host_data),
		.host_ok           (host_ok),
		.rx_dropped        (rx_dropped)
	);

	// Clock: 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Sequencer state as the bench sees it
	phase_t     seq_phase = PH_ADDR;
	bit         seq_armed = 1'b0;
	bit   [6:0] slave_addr = '0;
	logic [7:0] tx_bytes[$];
	logic [7:0] rx_bytes[$];

	res_t expected_results[$];
	res_t want_res;
	int   mismatches  = 0;
	int   words_sent  = 0;
	int   burst_left  = 0;
	int   pop_percent = 25;
	int   cycles      = 0;
	int   stall_left  = 0;

	// Run-away guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Result side stalls: four patterns taken in turn from the cycle counter
	always @(posedge clk) begin
		case ((cycles / 256) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ((cycles % 4) != 3);
			default: begin
				if (stall_left > 0) begin
					stall_left <= stall_left - 1;
					out_ready  <= 1'b0;
				end else begin
					if ($urandom_range(0, 15) == 0)
						stall_left <= $urandom_range(1, 12);
					out_ready <= 1'b1;
				end
			end
		endcase
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Compare each result word with the oldest prediction
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing pending", 0, 0);
			end else begin
				want_res = expected_results.pop_front();
				check_field("phase", phase, want_res.phase);
				check_field("waiting_for_start", waiting_for_start, want_res.waiting_for_start);
				check_field("sda_drive", sda_drive, want_res.sda_drive);
				check_field("load_enable", load_enable, want_res.load_enable);
				check_field("load_byte", load_byte, want_res.load_byte);
				check_field("one_bit_shift", one_bit_shift, want_res.one_bit_shift);
				check_field("host_data", host_data, want_res.host_data);
				check_field("host_ok", host_ok, want_res.host_ok);
				check_field("rx_dropped", rx_dropped, want_res.rx_dropped);
			end
		end
	end

	// Next sequencer state and result word for one event
	function automatic res_t next_bus_state(act_t act, logic [7:0] sb, logic [7:0] hb);
		res_t r;
		r = '0;
		case (act)
			ACT_START: begin
				seq_phase = PH_ADDR;
				seq_armed = 1'b1;
			end
			ACT_OVF: begin
				if (seq_armed) begin
					case (seq_phase)
						PH_ADDR: begin
							// general call or own address acks; bit 0 picks direction
							if (sb == 8'h00 || sb[7:1] == slave_addr) begin
								seq_phase = sb[0] ? PH_SEND : PH_RECV;
								r.load_enable = 1'b1;
							end else begin
								seq_armed = 1'b0;
							end
						end
						PH_SEND, PH_CHK_REPLY: begin
							if (seq_phase == PH_CHK_REPLY && sb != 8'h00) begin
								seq_armed = 1'b0;  // master NACK
							end else if (tx_bytes.size() > 0) begin
								r.load_byte   = tx_bytes.pop_front();
								r.load_enable = 1'b1;
								seq_phase     = PH_REQ_REPLY;
							end else begin
								seq_armed = 1'b0;  // nothing to send
							end
						end
						PH_REQ_REPLY: begin
							seq_phase     = PH_CHK_REPLY;
							r.load_enable = 1'b1;
						end
						PH_RECV: seq_phase = PH_GET_ACK;
						PH_GET_ACK: begin
							if (rx_bytes.size() < Q_DEPTH)
								rx_bytes.push_back(sb);
							else
								r.rx_dropped = 1'b1;
							seq_phase     = PH_RECV;
							r.load_enable = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ACT_PUSH: begin
				if (tx_bytes.size() < Q_DEPTH) begin
					tx_bytes.push_back(hb);
					r.host_ok = 1'b1;
				end
			end
			default: begin
				if (rx_bytes.size() > 0) begin
					r.host_data = rx_bytes.pop_front();
					r.host_ok   = 1'b1;
				end
			end
		endcase
		r.phase             = seq_phase;
		r.waiting_for_start = !seq_armed;
		r.sda_drive         = seq_armed && (seq_phase inside {PH_SEND, PH_REQ_REPLY, PH_RECV});
		r.one_bit_shift     = seq_armed && (seq_phase inside {PH_SEND, PH_CHK_REPLY, PH_RECV});
		return r;
	endfunction

	function automatic logic [7:0] rand8();
		return 8'($urandom_range(0, 255));
	endfunction

	// Address byte: mostly our own, sometimes general call or a random one
	function automatic logic [7:0] addr_byte(bit rd);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 8'h00;
		else if (pick == 1)
			return rand8();
		return {slave_addr, rd};
	endfunction

	// Send one event word; the sender may idle between bursts of random length
	task automatic send_word(act_t act, logic [7:0] sb, logic [7:0] hb);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid   <= 1'b1;
		action     <= act;
		shift_byte <= sb;
		host_byte  <= hb;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_results.push_back(next_bus_state(act, sb, hb));
		burst_left--;
		words_sent++;
	endtask

	task automatic wait_idle();
		in_valid   <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_own_address(logic [6:0] addr);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= addr;
		@(posedge clk);
		cfg_we     <= 1'b0;
		slave_addr = addr;
	endtask

	// Master writes: address, then ack slot and data byte per received byte
	task automatic rx_transaction(int n);
		send_word(ACT_START, rand8(), rand8());
		send_word(ACT_OVF, addr_byte(1'b0), rand8());
		repeat (n) begin
			send_word(ACT_OVF, rand8(), rand8());
			send_word(ACT_OVF, rand8(), rand8());
			if ($urandom_range(0, 99) < pop_percent)
				send_word(ACT_POP, rand8(), rand8());
		end
	endtask

	// Master reads: address, then data, reply request and ACK/NACK per byte
	task automatic tx_transaction(int n, bit nack_ok);
		send_word(ACT_START, rand8(), rand8());
		send_word(ACT_OVF, addr_byte(1'b1), rand8());
		send_word(ACT_OVF, rand8(), rand8());
		repeat (n) begin
			send_word(ACT_OVF, rand8(), rand8());
			send_word(ACT_OVF, (nack_ok && $urandom_range(0, 7) == 0) ? rand8() : 8'h00,
				rand8());
			if ($urandom_range(0, 3) == 0)
				send_word(ACT_PUSH, rand8(), rand8());
		end
	endtask

	task automatic test_reset_defaults();
		send_word(ACT_POP, 8'h00, 8'h00);
		send_word(ACT_OVF, 8'hFF, 8'hFF);
		send_word(ACT_PUSH, 8'h00, 8'hA5);
	endtask

	// own_address is zero: general call write, extreme data bytes
	task automatic test_general_call_receive();
		send_word(ACT_START, 8'h00, 8'h00);
		send_word(ACT_OVF, 8'h00, 8'h00);
		send_word(ACT_OVF, 8'h12, 8'h00);
		send_word(ACT_OVF, 8'hFF, 8'h00);
		send_word(ACT_OVF, 8'h34, 8'h00);
		send_word(ACT_OVF, 8'h00, 8'h00);
		send_word(ACT_POP, 8'h00, 8'h00);
		send_word(ACT_POP, 8'h00, 8'h00);
		send_word(ACT_POP, 8'h00, 8'h00);
	endtask

	// Highest address: read the one queued byte, ending when the queue runs empty, then a read with an empty queue
	task automatic test_addressed_transmit();
		set_own_address(7'h7F);
		send_word(ACT_PUSH, 8'h00, 8'h00);
		send_word(ACT_START, 8'h00, 8'h00);
		send_word(ACT_OVF, 8'hFF, 8'h00);
		send_word(ACT_OVF, 8'h00, 8'h00);
		send_word(ACT_OVF, 8'h00, 8'h00);
		send_word(ACT_OVF, 8'h00, 8'h00);
		send_word(ACT_OVF, 8'h00, 8'h00);
		send_word(ACT_OVF, 8'h01, 8'h00);
		send_word(ACT_START, 8'h00, 8'h00);
		send_word(ACT_OVF, 8'hFF, 8'h00);
		send_word(ACT_OVF, 8'h00, 8'h00);
	endtask

	task automatic test_address_mismatch();
		send_word(ACT_START, 8'h00, 8'h00);
		send_word(ACT_OVF, 8'h02, 8'h00);
		send_word(ACT_OVF, 8'h00, 8'h00);
	endtask

	// Fill both queues past their depth, then empty them over the bus and host side
	task automatic test_queue_limits();
		repeat (Q_DEPTH + 2) send_word(ACT_PUSH, rand8(), rand8());
		pop_percent = 0;
		rx_transaction(Q_DEPTH + 2);
		repeat (Q_DEPTH + 1) send_word(ACT_POP, rand8(), rand8());
		tx_transaction(Q_DEPTH, 1'b0);
	endtask

	task automatic test_random_traffic();
		logic [6:0] addr_list[4];
		int         pops[4];
		int         target;
		addr_list = '{7'h00, 7'h7F, 7'h2A, 7'h00};
		pops      = '{25, 5, 60, 30};
		addr_list[3] = 7'($urandom_range(1, 126));
		for (int p = 0; p < 4; p++) begin
			set_own_address(addr_list[p]);
			pop_percent = pops[p];
			target      = words_sent + 270;
			while (words_sent < target) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: rx_transaction($urandom_range(0, 20));
					4, 5, 6: begin
						repeat ($urandom_range(0, 6)) send_word(ACT_PUSH, rand8(), rand8());
						tx_transaction($urandom_range(0, 12), 1'b1);
					end
					7: repeat ($urandom_range(1, 6))
						send_word($urandom_range(0, 1) ? ACT_PUSH : ACT_POP, rand8(), rand8());
					default: repeat ($urandom_range(1, 8))
						send_word(act_t'($urandom_range(0, 3)), rand8(), rand8());
				endcase
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_general_call_receive();
		test_addressed_transmit();
		test_address_mismatch();
		test_queue_limits();
		test_random_traffic();
		wait_idle();
		if (expected_results.size() != 0)
			report_mismatch("results never returned", 0, expected_results.size());
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[i2c_slave_byte_sequencer_top.f]
sv/i2cs_pkg.sv
sv/i2cs_fifo.sv
sv/i2cs_seq.sv
sv/i2c_slave_byte_sequencer_top.sv
sim/tb_i2c_slave_byte_sequencer_top.sv
